[hdl/ohr_pkg.sv]
// ----------------------------------------------------------------------------
// ohr_pkg
// Shared types and constants of the overwriting history ring.
// ----------------------------------------------------------------------------
package ohr_pkg;

	// Fixed field widths
	localparam int CW  = 11;   // slot count, held count
	localparam int PW  = 32;   // payload handle
	localparam int TW  = 64;   // timestamp, totals, positions

	// Reset value of the slot count register
	localparam int unsigned SLOTS_RESET = 1024;

	// Operation codes carried on s_tuser
	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	// One stored ring entry
	typedef struct packed {
		logic          stamp_ok;
		logic [TW-1:0] stamp;
		logic [PW-1:0] payload;
	} entry_t;

	localparam int EW = $bits(entry_t);

endpackage

[hdl/ohr_ram.sv]
// ----------------------------------------------------------------------------
// ohr_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ohr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[hdl/overwriting_history_ring_core.sv]
// ----------------------------------------------------------------------------
// overwriting_history_ring_core
// Timeshift history ring of payload handles and timestamps, oldest overwritten.
// ----------------------------------------------------------------------------
// Usage
//   Input stream (s_*): s_tuser selects the operation, push or read. A push
//   stores payload, stamp and stamp_valid at the head of the ring; once the
//   ring is full (slots_in_use, clamped) the oldest is overwritten. A read
//   names an absolute write position, returns the payload if still held.
//   Output stream (m_*): one result transaction per input transaction, in
//   order, with the hit flag on m_tuser and counts and span on m_tdata.
//   APB port: register 0 (byte address 0) is slots_in_use; writing it empties
//   the ring but keeps the write total and the span. Write it only when idle.
// Sequence
//   The accept cycle issues the RAM access (write at head plus read of the
//   oldest stamp, or read of the payload); the busy state then consumes the
//   registered RAM data and loads the output register. s_tready stays low
//   from accept until that load, so transactions do not overlap.
// Reset and stall
//   arst_n empties the ring, clears totals and span, sets slots_in_use to
//   1024. A stalled receiver holds the result in the output register; the next
//   transaction is still accepted and then waits in the busy state.
// ----------------------------------------------------------------------------
module overwriting_history_ring_core
	import ohr_pkg::*;
#(
	parameter int DEPTH = 1024
) (
	input  logic         clk,
	input  logic         arst_n,

	// Input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [167:0] s_tdata,   // payload[31:0], stamp[95:32], stamp_valid[96],
	                                // position[160:97], zero fill [167:161]
	input  logic         s_tuser,   // func

	// Result stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [175:0] m_tdata,   // read_payload[31:0], held_count[42:32],
	                                // written_total[106:43], span[170:107],
	                                // zero fill [175:171]
	output logic         m_tuser,   // hit

	// Configuration port
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int AW  = $clog2(DEPTH);
	localparam int XW  = (AW + 1 > CW) ? AW + 1 : CW;   // slot arithmetic width
	localparam int XW1 = XW + 1;
	localparam int SIZE_RST = (SLOTS_RESET > DEPTH) ? DEPTH : SLOTS_RESET;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_BUSY = 2'b10
	} state_t;

	// Wrap-around increment of a slot index within the active ring size
	function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s,
	                                           input logic [CW-1:0] sz);
		logic [XW-1:0] nx;
		nx = XW'(s) + XW'(1);
		return (nx == XW'(sz)) ? '0 : nx[AW-1:0];
	endfunction

	// ------------------------------------------------------------------
	// State
	// ------------------------------------------------------------------
	state_t        state_q;
	logic [CW-1:0] slots_q;     // register as written
	logic [CW-1:0] size_q;      // clamped ring size
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [CW-1:0] fill_q;
	logic [TW-1:0] total_q;
	logic [TW-1:0] first_q;     // absolute position of the oldest entry
	logic [TW-1:0] span_q;

	// Busy-state context
	logic          func_s1;
	logic [TW-1:0] stamp_s1;
	logic          span_chk_s1;
	logic [TW-1:0] rel_s1;

	// Output register
	logic          out_valid_q;
	logic          hit_q;
	logic [PW-1:0] rpay_q;
	logic [CW-1:0] held_q;
	logic [TW-1:0] otot_q;
	logic [TW-1:0] ospan_q;

	// ------------------------------------------------------------------
	// Input unpacking
	// ------------------------------------------------------------------
	logic          in_func;
	logic [PW-1:0] in_payload;
	logic [TW-1:0] in_stamp;
	logic          in_stamp_valid;
	logic [TW-1:0] in_position;

	assign in_func        = s_tuser;
	assign in_payload     = s_tdata[31:0];
	assign in_stamp       = s_tdata[95:32];
	assign in_stamp_valid = s_tdata[96];
	assign in_position    = s_tdata[160:97];

	logic in_acc;
	logic push_acc;
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign push_acc = in_acc && (in_func == FUNC_PUSH);

	// ------------------------------------------------------------------
	// Configuration port
	// ------------------------------------------------------------------
	logic          cfg_wr;
	logic [CW-1:0] cfg_val;
	logic [CW-1:0] cfg_size;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready && !paddr[2];
	assign cfg_val = pwdata[CW-1:0];
	assign prdata  = paddr[2] ? 32'd0 : {{(32-CW){1'b0}}, slots_q};

	// Clamp the slot count: zero acts as one, above the built depth as depth
	always_comb begin
		if (cfg_val == '0) begin
			cfg_size = CW'(1);
		end else if (32'(cfg_val) > 32'(DEPTH)) begin
			cfg_size = CW'(DEPTH);
		end else begin
			cfg_size = cfg_val;
		end
	end

	// ------------------------------------------------------------------
	// Accept cycle: push bookkeeping and RAM address
	// ------------------------------------------------------------------
	logic          full;
	logic [AW-1:0] tail_nx;
	logic [CW-1:0] fill_nx;
	logic          span_chk;
	logic [XW-1:0] rel_low;
	logic [XW:0]   idx_sum;
	logic [XW:0]   idx_wrap;
	logic [AW-1:0] rd_idx;

	assign full     = (fill_q == size_q);
	assign tail_nx  = full ? slot_inc(tail_q, size_q) : tail_q;
	assign fill_nx  = full ? fill_q : fill_q + CW'(1);
	assign span_chk = (fill_nx > CW'(1)) && in_stamp_valid;

	// Slot of a read: tail plus distance from the oldest position, wrapped.
	// Only the low bits matter; a miss discards whatever is read.
	assign rel_low  = in_position[XW-1:0] - first_q[XW-1:0];
	assign idx_sum  = XW1'(tail_q) + XW1'(rel_low);
	assign idx_wrap = (idx_sum >= XW1'(size_q)) ? idx_sum - XW1'(size_q) : idx_sum;
	assign rd_idx   = idx_wrap[AW-1:0];

	entry_t        wr_entry;
	entry_t        rd_entry;
	logic [EW-1:0] rd_data;

	assign wr_entry.stamp_ok = in_stamp_valid;
	assign wr_entry.stamp    = in_stamp;
	assign wr_entry.payload  = in_payload;
	assign rd_entry          = entry_t'(rd_data);

	// Push writes the head and reads the (new) oldest slot, never the same one
	// when more than one entry is held; read looks up the payload.
	ohr_ram #(
		.WIDTH (EW),
		.DEPTH (DEPTH)
	) u_entry_ram (
		.clk     (clk),
		.wr_en   (push_acc),
		.wr_addr (head_q),
		.wr_data (wr_entry),
		.rd_en   (in_acc),
		.rd_addr ((in_func == FUNC_PUSH) ? tail_nx : rd_idx),
		.rd_data (rd_data)
	);

	// ------------------------------------------------------------------
	// Busy state: hit decision, span update, output load
	// ------------------------------------------------------------------
	logic          rd_hit;
	logic [TW-1:0] span_nx;
	logic          load;

	assign rd_hit  = (rel_s1[TW-1:CW] == '0) && (rel_s1[CW-1:0] < fill_q);
	assign span_nx = ((func_s1 == FUNC_PUSH) && span_chk_s1 && rd_entry.stamp_ok)
	               ? stamp_s1 - rd_entry.stamp : span_q;
	assign load    = (state_q == ST_BUSY) && (!out_valid_q || m_tready);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_BUSY;
					end
				end
				ST_BUSY: begin
					// hold until the output register is free
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Ring state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q <= CW'(SLOTS_RESET);
			size_q  <= CW'(SIZE_RST);
			head_q  <= '0;
			tail_q  <= '0;
			fill_q  <= '0;
			total_q <= '0;
			first_q <= '0;
			span_q  <= '0;
		end else begin
			if (cfg_wr) begin
				// empty the ring; totals and span stay
				slots_q <= cfg_val;
				size_q  <= cfg_size;
				head_q  <= '0;
				tail_q  <= '0;
				fill_q  <= '0;
				first_q <= total_q;
			end else if (push_acc) begin
				head_q  <= slot_inc(head_q, size_q);
				tail_q  <= tail_nx;
				fill_q  <= fill_nx;
				total_q <= total_q + TW'(1);
				if (full) begin
					first_q <= first_q + TW'(1);
				end
			end
			if (load) begin
				span_q <= span_nx;
			end
		end
	end

	// Context of the transaction in flight
	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_s1     <= in_func;
			stamp_s1    <= in_stamp;
			span_chk_s1 <= span_chk;
			rel_s1      <= in_position - first_q;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			hit_q   <= (func_s1 == FUNC_PUSH) ? 1'b1 : rd_hit;
			rpay_q  <= ((func_s1 == FUNC_READ) && rd_hit) ? rd_entry.payload : '0;
			held_q  <= fill_q;
			otot_q  <= total_q;
			ospan_q <= span_nx;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = hit_q;
	assign m_tdata  = {5'd0, ospan_q, otot_q, held_q, rpay_q};

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= size_q)
		else $error("fill count exceeds ring size");

	a_full_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == size_q) |-> (head_q == tail_q))
		else $error("full ring with head and tail apart");

	a_window: assert property (@(posedge clk) disable iff (!arst_n)
		(total_q - first_q) == TW'(fill_q))
		else $error("oldest position out of step with totals");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BUSY && out_valid_q && !m_tready) |=> (state_q == ST_BUSY))
		else $error("pending result overwritten");

	a_span_push_only: assert property (@(posedge clk) disable iff (!arst_n)
		(load && func_s1 == FUNC_READ) |=> $stable(span_q))
		else $error("span changed on a read");

endmodule
